FILE: hdl/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types, widths and helpers for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PROD_W = 2 * WORD_WIDTH;                 // one raw product
  localparam int SUM_W  = PROD_W + 2;                     // sum of four products
  localparam int ROOT_W = WORD_WIDTH + 1;                 // norm and divisor
  localparam int NUM_W  = WORD_WIDTH + FRAC_BITS;         // scaled dividend
  localparam int IN_DW  = ((9 * WORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_FW = 4 * WORD_WIDTH + (WORD_WIDTH - 1) + 2;
  localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [3:0] {
    OP_NEG   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_PROD  = 4'd3,
    OP_SCALE = 4'd4,
    OP_DIV   = 4'd5,
    OP_CONJ  = 4'd6,
    OP_NORM  = 4'd7,
    OP_NRMZ  = 4'd8,
    OP_EQ    = 4'd9,
    OP_NONE  = 4'd15
  } op_t;

  typedef logic [3:0][WORD_WIDTH-1:0] quad_t;

  typedef struct packed {
    op_t                   op;
    quad_t                 a;
    quad_t                 b;
    logic [WORD_WIDTH-1:0] s;
  } cmd_t;

  // terms of the hamilton product that enter with a minus sign, bit per term
  localparam logic [3:0] PROD_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  function automatic logic signed [SUM_W-1:0] ext_w(input logic [WORD_WIDTH-1:0] x);
    return {{(SUM_W-WORD_WIDTH){x[WORD_WIDTH-1]}}, x};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_p(input logic [PROD_W-1:0] x);
    return {{(SUM_W-PROD_W){x[PROD_W-1]}}, x};
  endfunction

  function automatic logic [WORD_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] x);
    logic [WORD_WIDTH-1:0] r;
    if ((&x[SUM_W-1:WORD_WIDTH-1]) || ~(|x[SUM_W-1:WORD_WIDTH-1])) begin
      r = x[WORD_WIDTH-1:0];
    end else if (x[SUM_W-1]) begin
      r = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hdl/qalu_front.sv
// ----------------------------------------------------------------------------
// qalu_front
// Input register: takes requests and decodes the operation code.
// ----------------------------------------------------------------------------
module qalu_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [qalu_pkg::IN_DW-1:0]  s_tdata,
  input  logic [3:0]                  s_tuser,
  output logic                        out_valid,
  input  logic                        out_ready,
  output qalu_pkg::cmd_t              out_cmd
);

  qalu_pkg::cmd_t cmd_next;

  assign s_tready = !out_valid || out_ready;

  always_comb begin
    localparam int W = qalu_pkg::WORD_WIDTH;
    cmd_next.a = s_tdata[4*W-1:0];
    cmd_next.b = s_tdata[8*W-1:4*W];
    cmd_next.s = s_tdata[9*W-1:8*W];
    // unused codes run as a no-op giving zeros
    if (s_tuser <= 4'(qalu_pkg::OP_EQ)) begin
      cmd_next.op = qalu_pkg::op_t'(s_tuser);
    end else begin
      cmd_next.op = qalu_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      out_cmd <= cmd_next;
    end
  end

endmodule

FILE: hdl/qalu_fifo.sv
// ----------------------------------------------------------------------------
// qalu_fifo
// Short command queue between the front and the execution pipeline.
// ----------------------------------------------------------------------------
module qalu_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  qalu_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output qalu_pkg::cmd_t rd_data
);

  qalu_pkg::cmd_t                 mem [qalu_pkg::FIFO_DEPTH];
  logic [qalu_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [qalu_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [qalu_pkg::FIFO_AW:0]     count;
  logic                           push;
  logic                           pop;

  assign wr_ready = count != (qalu_pkg::FIFO_AW+1)'(qalu_pkg::FIFO_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/qalu_back.sv
// ----------------------------------------------------------------------------
// qalu_back
// Execution pipeline: multipliers, sums, bit-per-stage square root and
// bit-per-stage division in four lanes, then the output register.
// ----------------------------------------------------------------------------
module qalu_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  qalu_pkg::cmd_t               in_cmd,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [qalu_pkg::OUT_DW-1:0]  m_tdata
);

  localparam int W    = qalu_pkg::WORD_WIDTH;
  localparam int F    = qalu_pkg::FRAC_BITS;
  localparam int PW   = qalu_pkg::PROD_W;
  localparam int SW   = qalu_pkg::SUM_W;
  localparam int RW   = qalu_pkg::ROOT_W;
  localparam int NW   = qalu_pkg::NUM_W;
  localparam int QW   = 2 * RW;          // radicand, an even number of bits
  localparam int RMW  = RW + 3;
  localparam int NV   = RW + NW + 3;

  typedef struct packed {
    qalu_pkg::op_t   op;
    qalu_pkg::quad_t q;
    logic            eq;
    qalu_pkg::quad_t amag;
    logic [3:0]      asign;
    logic [W-1:0]    smag;
    logic            ssign;
  } st_t;

  typedef struct packed {
    st_t             c;
    logic [RW-1:0]   root;
    logic [RMW-1:0]  rem;
    logic [QW-1:0]   x;
  } sq_t;

  typedef struct packed {
    qalu_pkg::op_t          op;
    qalu_pkg::quad_t        q;
    logic                   eq;
    logic [W-2:0]           sc;
    logic                   err;
    logic                   act;
    logic [3:0]             qsign;
    logic [RW-1:0]          d;
    logic [3:0][RW-1:0]     rem;
    logic [3:0][NW-1:0]     num;
  } dv_t;

  function automatic sq_t sq_step(input sq_t i);
    sq_t            o;
    logic [RMW-1:0] r2;
    logic [RMW-1:0] tr;
    o  = i;
    r2 = {i.rem[RMW-3:0], i.x[QW-1 -: 2]};
    tr = RMW'({i.root, 2'b01});
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {i.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {i.root[RW-2:0], 1'b0};
    end
    o.x = {i.x[QW-3:0], 2'b00};
    return o;
  endfunction

  function automatic dv_t dv_step(input dv_t i);
    dv_t         o;
    logic [RW:0] t;
    logic        ge;
    o = i;
    for (int r = 0; r < 4; r++) begin
      t  = {i.rem[r], i.num[r][NW-1]};
      ge = t >= {1'b0, i.d};
      o.rem[r] = ge ? RW'(t - {1'b0, i.d}) : t[RW-1:0];
      o.num[r] = {i.num[r][NW-2:0], ge};
    end
    return o;
  endfunction

  logic                   adv;
  logic [NV-1:0]          vld;
  qalu_pkg::cmd_t         c1;
  logic signed [PW-1:0]   p1 [4][4];
  logic signed [W-1:0]    mx [4][4];
  logic signed [W-1:0]    my [4][4];
  st_t                    st;
  logic signed [SW-1:0]   sumsq;
  sq_t                    sq_r [RW+1];
  dv_t                    dv_in;
  dv_t                    dv_r [NW+1];
  qalu_pkg::quad_t        q_fin;

  // whole pipeline moves together, held only by a full output word
  assign adv      = !m_tvalid || m_tready;
  assign in_ready = adv;

  // operand select for the sixteen multipliers
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int t = 0; t < 4; t++) begin
        mx[r][t] = '0;
        my[r][t] = '0;
        case (in_cmd.op)
          qalu_pkg::OP_PROD: begin
            mx[r][t] = $signed(in_cmd.a[t]);
            my[r][t] = $signed(in_cmd.b[r ^ t]);
          end
          qalu_pkg::OP_SCALE: begin
            if (t == 0) begin
              mx[r][t] = $signed(in_cmd.a[r]);
              my[r][t] = $signed(in_cmd.s);
            end
          end
          qalu_pkg::OP_NORM, qalu_pkg::OP_NRMZ: begin
            if (t == 0) begin
              mx[r][t] = $signed(in_cmd.a[r]);
              my[r][t] = $signed(in_cmd.a[r]);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= in_cmd;
      for (int r = 0; r < 4; r++) begin
        for (int t = 0; t < 4; t++) begin
          p1[r][t] <= mx[r][t] * my[r][t];
        end
      end
    end
  end

  // sums, shifts and the plain componentwise ops
  always_comb begin
    logic signed [SW-1:0] as;
    logic signed [SW-1:0] bs;
    logic signed [SW-1:0] psum;
    st       = '0;
    sumsq    = '0;
    st.op    = c1.op;
    st.ssign = c1.s[W-1];
    st.smag  = c1.s[W-1] ? W'(-c1.s) : c1.s;
    st.eq    = (c1.op == qalu_pkg::OP_EQ) && (c1.a == c1.b);
    for (int r = 0; r < 4; r++) begin
      as   = qalu_pkg::ext_w(c1.a[r]);
      bs   = qalu_pkg::ext_w(c1.b[r]);
      psum = '0;
      for (int t = 0; t < 4; t++) begin
        psum = psum + (qalu_pkg::PROD_NEG[r][t] ? -qalu_pkg::ext_p(p1[r][t])
                                                 : qalu_pkg::ext_p(p1[r][t]));
      end
      sumsq        = sumsq + qalu_pkg::ext_p(p1[r][0]);
      st.asign[r]  = c1.a[r][W-1];
      st.amag[r]   = c1.a[r][W-1] ? W'(-c1.a[r]) : c1.a[r];
      case (c1.op)
        qalu_pkg::OP_NEG:   st.q[r] = qalu_pkg::sat(-as);
        qalu_pkg::OP_ADD:   st.q[r] = qalu_pkg::sat(as + bs);
        qalu_pkg::OP_SUB:   st.q[r] = qalu_pkg::sat(as - bs);
        qalu_pkg::OP_PROD:  st.q[r] = qalu_pkg::sat(psum >>> F);
        qalu_pkg::OP_SCALE: st.q[r] = qalu_pkg::sat(qalu_pkg::ext_p(p1[r][0]) >>> F);
        qalu_pkg::OP_CONJ:  st.q[r] = (r == 0) ? c1.a[r] : qalu_pkg::sat(-as);
        default:            st.q[r] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0].c    <= st;
      sq_r[0].root <= '0;
      sq_r[0].rem  <= '0;
      sq_r[0].x    <= QW'(sumsq);
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1] <= sq_step(sq_r[k]);
      end
    end
  end

  // divisor, error and norm output from the finished root
  always_comb begin
    logic [RW-1:0] n;
    logic          is_div;
    logic          is_nrmz;
    n       = sq_r[RW].root;
    is_div  = sq_r[RW].c.op == qalu_pkg::OP_DIV;
    is_nrmz = sq_r[RW].c.op == qalu_pkg::OP_NRMZ;
    dv_in.op  = sq_r[RW].c.op;
    dv_in.q   = sq_r[RW].c.q;
    dv_in.eq  = sq_r[RW].c.eq;
    if (sq_r[RW].c.op == qalu_pkg::OP_NORM) begin
      dv_in.sc = (n > RW'({(W-1){1'b1}})) ? {(W-1){1'b1}} : n[W-2:0];
    end else begin
      dv_in.sc = '0;
    end
    dv_in.d   = is_div ? {1'b0, sq_r[RW].c.smag} : n;
    dv_in.err = (is_div && sq_r[RW].c.smag == '0) || (is_nrmz && n == '0);
    dv_in.act = (is_div || is_nrmz) && !dv_in.err;
    dv_in.rem = '0;
    for (int r = 0; r < 4; r++) begin
      dv_in.qsign[r] = sq_r[RW].c.asign[r] ^ (is_div && sq_r[RW].c.ssign);
      dv_in.num[r]   = {sq_r[RW].c.amag[r], {F{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv_in;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= dv_step(dv_r[k]);
      end
    end
  end

  // quotients take their sign and saturate
  always_comb begin
    logic signed [SW-1:0] mag;
    for (int r = 0; r < 4; r++) begin
      mag = $signed(SW'(dv_r[NW].num[r]));
      if (dv_r[NW].act) begin
        q_fin[r] = qalu_pkg::sat(dv_r[NW].qsign[r] ? -mag : mag);
      end else begin
        q_fin[r] = dv_r[NW].q[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[NV-2:0], in_valid};
      m_tvalid <= vld[NV-1];
    end
    if (adv) begin
      m_tdata <= {{(qalu_pkg::OUT_DW-qalu_pkg::OUT_FW){1'b0}}, dv_r[NW].err,
                  dv_r[NW].eq, dv_r[NW].sc, q_fin};
    end
  end

endmodule

FILE: hdl/quaternion_alu.sv
// ----------------------------------------------------------------------------
// quaternion_alu
// Quaternion arithmetic unit in signed Q16.16 with saturation.
//
//   channel  dir  fields (lowest bit first)
//   s_*      in   tdata: a_real a_i a_j a_k b_real b_i b_j b_k scalar_in
//                 tuser: req_type
//   m_*      out  tdata: q_real q_i q_j q_k scalar_out is_equal div_error
//
// One word accepted per cycle while the queue has room, one result word per
// request, in order. Every request passes through the 33-stage square root
// followed by the 48-stage divider.
// rst is synchronous and empties the input register, the queue and the
// pipeline. A stalled output holds the pipeline; the four-entry queue
// keeps the input side taking words until it fills.
// ----------------------------------------------------------------------------
module quaternion_alu (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [qalu_pkg::IN_DW-1:0]   s_tdata,   // a_real a_i a_j a_k b_real b_i b_j b_k scalar_in
  input  logic [3:0]                   s_tuser,   // req_type
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [qalu_pkg::OUT_DW-1:0]  m_tdata    // q_real q_i q_j q_k scalar_out is_equal div_error
);

  logic           fr_valid;
  logic           fr_ready;
  qalu_pkg::cmd_t fr_cmd;
  logic           qu_valid;
  logic           qu_ready;
  qalu_pkg::cmd_t qu_cmd;

  qalu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_cmd   (fr_cmd)
  );

  qalu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_cmd),
    .rd_valid (qu_valid),
    .rd_ready (qu_ready),
    .rd_data  (qu_cmd)
  );

  qalu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (qu_valid),
    .in_ready (qu_ready),
    .in_cmd   (qu_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_alu: a Q16.16 predictor computes the
// expected result of every request and a checker compares each output word
// in order, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 200;

  typedef logic signed [31:0] word_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    word_t       q[4];
    logic [30:0] norm;
    logic        eq;
    logic        err;
  } result_t;

  logic                        clk = 0;
  logic                        rst = 1;
  logic                        s_tvalid = 0;
  logic                        s_tready;
  logic [qalu_pkg::IN_DW-1:0]  s_tdata = '0;
  logic [3:0]                  s_tuser = '0;
  logic                        m_tvalid;
  logic                        m_tready = 0;
  logic [qalu_pkg::OUT_DW-1:0] m_tdata;

  result_t pending_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      stall_left = 0;
  bit      quiet = 0;

  quaternion_alu u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic word_t sat_word(wide_t v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic wide_t mul(word_t x, word_t y);
    return wide_t'(x) * wide_t'(y);
  endfunction

  // floor square root of the sum of squares of the raw words
  function automatic logic [33:0] quad_norm(word_t a[4]);
    logic [67:0] acc;
    logic [67:0] t;
    logic [33:0] root;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += 68'(mul(a[i], a[i]));
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      t = 68'(root | (34'd1 << b));
      if (t * t <= acc) root = root | (34'd1 << b);
    end
    return root;
  endfunction

  function automatic word_t fx_quot(word_t x, longint d);
    longint n;
    n = longint'(x) * 65536;
    return sat_word(wide_t'(n / d));
  endfunction

  function automatic result_t predict_quat(logic [3:0] op, word_t a[4], word_t b[4],
                                           word_t s);
    result_t     r;
    logic [33:0] n;
    for (int i = 0; i < 4; i++) r.q[i] = 0;
    r.norm = 0;
    r.eq = 0;
    r.err = 0;
    case (qalu_pkg::op_t'(op))
      qalu_pkg::OP_NEG:
        for (int i = 0; i < 4; i++) r.q[i] = sat_word(-wide_t'(a[i]));
      qalu_pkg::OP_ADD:
        for (int i = 0; i < 4; i++) r.q[i] = sat_word(wide_t'(a[i]) + b[i]);
      qalu_pkg::OP_SUB:
        for (int i = 0; i < 4; i++) r.q[i] = sat_word(wide_t'(a[i]) - b[i]);
      qalu_pkg::OP_PROD: begin
        r.q[0] = sat_word((mul(a[0], b[0]) - mul(a[1], b[1]) - mul(a[2], b[2])
                           - mul(a[3], b[3])) >>> qalu_pkg::FRAC_BITS);
        r.q[1] = sat_word((mul(a[0], b[1]) + mul(a[1], b[0]) + mul(a[2], b[3])
                           - mul(a[3], b[2])) >>> qalu_pkg::FRAC_BITS);
        r.q[2] = sat_word((mul(a[0], b[2]) - mul(a[1], b[3]) + mul(a[2], b[0])
                           + mul(a[3], b[1])) >>> qalu_pkg::FRAC_BITS);
        r.q[3] = sat_word((mul(a[0], b[3]) + mul(a[1], b[2]) - mul(a[2], b[1])
                           + mul(a[3], b[0])) >>> qalu_pkg::FRAC_BITS);
      end
      qalu_pkg::OP_SCALE:
        for (int i = 0; i < 4; i++) r.q[i] = sat_word(mul(a[i], s) >>> qalu_pkg::FRAC_BITS);
      qalu_pkg::OP_DIV: begin
        if (s == 0) r.err = 1;
        else for (int i = 0; i < 4; i++) r.q[i] = fx_quot(a[i], longint'(s));
      end
      qalu_pkg::OP_CONJ: begin
        r.q[0] = a[0];
        for (int i = 1; i < 4; i++) r.q[i] = sat_word(-wide_t'(a[i]));
      end
      qalu_pkg::OP_NORM: begin
        n = quad_norm(a);
        r.norm = (n > 34'h7fffffff) ? 31'h7fffffff : n[30:0];
      end
      qalu_pkg::OP_NRMZ: begin
        n = quad_norm(a);
        if (n == 0) r.err = 1;
        else for (int i = 0; i < 4; i++) r.q[i] = fx_quot(a[i], longint'(n));
      end
      qalu_pkg::OP_EQ:
        r.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]) && (a[3] == b[3]);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_req(logic [3:0] op, word_t a[4], word_t b[4], word_t s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {s, b[3], b[2], b[1], b[0], a[3], a[2], a[1], a[0]};
    pending_results.push_back(predict_quat(op, a, b, s));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 0;
      3, 4:    return word_t'($urandom_range(0, 8 << 16)) - (4 << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_fill(logic [3:0] op, word_t av, word_t bv, word_t s);
    word_t a[4];
    word_t b[4];
    for (int i = 0; i < 4; i++) begin
      a[i] = av;
      b[i] = bv;
    end
    send_req(op, a, b, s);
  endtask

  task automatic test_each_op_extremes();
    for (int op = 0; op < 10; op++) begin
      send_fill(4'(op), 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_fill(4'(op), 32'sh80000000, 32'sh80000000, 32'sh80000000);
    end
  endtask

  task automatic test_special_cases();
    send_fill(qalu_pkg::OP_DIV, 32'sh00010000, 0, 0);   // divide by zero
    send_fill(qalu_pkg::OP_NRMZ, 0, 0, 0);               // normalize zero quaternion
    send_fill(qalu_pkg::OP_EQ, 32'sh00012345, 32'sh00012345, 0);
    send_fill(qalu_pkg::OP_EQ, 32'sh00012345, 32'sh00012346, 0);
    send_fill(qalu_pkg::OP_NORM, 32'sh80000000, 0, 0);   // sum of squares exceeds 64 bits
    for (int op = 10; op < 16; op++) send_fill(4'(op), $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_requests(int count);
    word_t a[4];
    word_t b[4];
    logic [3:0] op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      for (int i = 0; i < 4; i++) begin
        a[i] = rand_word();
        b[i] = rand_word();
      end
      if (op == qalu_pkg::OP_EQ && $urandom_range(0, 1)) begin
        b = a;
        if ($urandom_range(0, 1)) b[$urandom_range(0, 3)] ^= 32'(1) << $urandom_range(0, 31);
      end
      if (n >= count - 100) quiet = 1;
      send_req(op, a, b, rand_word());
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // output-side stall bursts
  always @(posedge clk) begin
    if (quiet) begin
      m_tready <= 1;
    end else if (stall_left > 0) begin
      m_tready <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready <= 0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[quaternion_alu] ERROR");
      $finish;
    end else if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[63:0], 0);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_tdata[32*i +: 32] !== want.q[i])
            report_mismatch($sformatf("q[%0d]", i), m_tdata[32*i +: 32], want.q[i]);
        if (m_tdata[158:128] !== want.norm) report_mismatch("scalar_out", m_tdata[158:128], want.norm);
        if (m_tdata[159] !== want.eq) report_mismatch("is_equal", m_tdata[159], want.eq);
        if (m_tdata[160] !== want.err) report_mismatch("div_error", m_tdata[160], want.err);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    test_each_op_extremes();
    test_special_cases();
    test_random_requests(830);
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("[quaternion_alu] OK");
    end else begin
      $display("[quaternion_alu] ERROR");
    end
    $finish;
  end

endmodule

FILE: quaternion_alu.f
hdl/qalu_pkg.sv
hdl/qalu_front.sv
hdl/qalu_fifo.sv
hdl/qalu_back.sv
hdl/quaternion_alu.sv
tb/sv/tb_top.sv
